// ----- rtl/u8u16_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the utf-8 to utf-16 stream converter
// no dependencies; imported by every module of the block

package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CpW    = 21;

  localparam logic [1:0] KIND_UNIT    = 2'd0;
  localparam logic [1:0] KIND_END_OK  = 2'd1;
  localparam logic [1:0] KIND_END_ERR = 2'd2;

  localparam logic [CpW-1:0]   CP_MAX       = 21'h10FFFF;
  localparam logic [CpW-1:0]   CP_SURR_LOW  = 21'h00D7FF;
  localparam logic [CpW-1:0]   CP_SURR_HIGH = 21'h00E000;
  localparam logic [CpW-1:0]   CP_BMP_MAX   = 21'h00FFFF;
  localparam logic [CpW-1:0]   CP_SUPP_BASE = 21'h010000;
  localparam logic [UnitW-1:0] HI_SURR_BASE = 16'hD800;
  localparam logic [UnitW-1:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [ByteW-1:0] CONT_MASK    = 8'b0011_1111;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    OP_UNIT,
    OP_PAIR,
    OP_END_OK,
    OP_END_ERR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CpW-1:0]    cp;     // code point, zero on end words
    logic [CountW-1:0] count;  // unit count after this entry
  } entry_t;

  // smallest legal code point for a given number of continuation bytes
  function automatic logic [CpW-1:0] min_cp(input logic [1:0] cont_len);
    logic [CpW-1:0] res;
    case (cont_len)
      2'd1:    res = 21'h000080;
      2'd2:    res = 21'h000800;
      2'd3:    res = 21'h010000;
      default: res = 21'h000000;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/u8u16_front.sv -----
`timescale 1ns / 1ps
// front part: takes input bytes, tracks sequence and capacity state, and
// hands units, pairs and end words to the queue; uses u8u16_pkg

module u8u16_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  max_units_we_i,
  input  logic [7:0]            max_units_i,
  output logic                  ent_valid_o,
  output u8u16_pkg::entry_t     ent_o
);
  import u8u16_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ERROR,
    MODE_STOPPED
  } mode_e;

  logic [CountW-1:0] max_units_q;
  logic [1:0]        pending_q, pending_d;
  logic [1:0]        seq_len_q, seq_len_d;
  logic [CpW-1:0]    acc_q, acc_d;
  logic [CountW-1:0] used_q, used_d;
  mode_e             mode_q, mode_d;

  logic [CpW-1:0]    acc_next;
  logic [CpW-1:0]    cp_e;
  logic [1:0]        len_e;
  logic              cp_bad;
  logic [CountW:0]   used_p1, used_p2;
  logic              ent_valid;
  entry_t            ent;

  assign acc_next = {acc_q[CpW-7:0], in_byte_i[5:0] & CONT_MASK[5:0]};
  assign cp_e     = (pending_q != 2'd0) ? acc_next : {14'd0, in_byte_i[6:0]};
  assign len_e    = (pending_q != 2'd0) ? seq_len_q : 2'd0;
  assign cp_bad   = (cp_e < min_cp(len_e)) || (cp_e > CP_MAX) ||
                    ((cp_e > CP_SURR_LOW) && (cp_e < CP_SURR_HIGH));
  assign used_p1  = {1'b0, used_q} + 9'd1;
  assign used_p2  = {1'b0, used_q} + 9'd2;

  always_comb begin
    logic do_emit;
    pending_d = pending_q;
    seq_len_d = seq_len_q;
    acc_d     = acc_q;
    used_d    = used_q;
    mode_d    = mode_q;
    ent_valid = 1'b0;
    ent       = '{op: OP_UNIT, cp: cp_e, count: used_p1[CountW-1:0]};
    do_emit   = 1'b0;
    if (accept_i) begin
      if (in_byte_i == 8'd0) begin
        ent_valid = 1'b1;
        ent.cp    = '0;
        ent.count = used_q;
        if (mode_q == MODE_ERROR || (mode_q == MODE_NORMAL && pending_q != 2'd0)) begin
          ent.op = OP_END_ERR;
        end else begin
          ent.op = OP_END_OK;
        end
        pending_d = '0;
        seq_len_d = '0;
        acc_d     = '0;
        used_d    = '0;
        mode_d    = MODE_NORMAL;
      end else if (mode_q != MODE_NORMAL) begin
        // swallow bytes until the terminator
      end else if (max_units_q == 8'd0) begin
        mode_d = MODE_STOPPED;
      end else if (pending_q != 2'd0) begin
        acc_d     = acc_next;
        pending_d = pending_q - 2'd1;
        do_emit   = (pending_q == 2'd1);
      end else if (in_byte_i[7] == 1'b0) begin
        seq_len_d = 2'd0;
        do_emit   = 1'b1;
      end else if (in_byte_i[7:5] == 3'b110) begin
        seq_len_d = 2'd1;
        pending_d = 2'd1;
        acc_d     = {16'd0, in_byte_i[4:0]};
      end else if (in_byte_i[7:4] == 4'b1110) begin
        seq_len_d = 2'd2;
        pending_d = 2'd2;
        acc_d     = {17'd0, in_byte_i[3:0]};
      end else if (in_byte_i[7:3] == 5'b11110) begin
        seq_len_d = 2'd3;
        pending_d = 2'd3;
        acc_d     = {18'd0, in_byte_i[2:0]};
      end else begin
        mode_d = MODE_ERROR;
      end

      if (do_emit) begin
        if (cp_bad) begin
          mode_d = MODE_ERROR;
        end else if (cp_e <= CP_BMP_MAX) begin
          if (used_p1 < {1'b0, max_units_q}) begin
            ent_valid = 1'b1;
            used_d    = used_p1[CountW-1:0];
          end else begin
            mode_d = MODE_STOPPED;
          end
        end else begin
          // a pair goes in whole or not at all
          if (used_p2 < {1'b0, max_units_q}) begin
            ent_valid = 1'b1;
            ent.op    = OP_PAIR;
            ent.count = used_p2[CountW-1:0];
            used_d    = used_p2[CountW-1:0];
          end else begin
            mode_d = MODE_STOPPED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= 8'd127;
      pending_q   <= '0;
      seq_len_q   <= '0;
      acc_q       <= '0;
      used_q      <= '0;
      mode_q      <= MODE_NORMAL;
    end else begin
      if (max_units_we_i) begin
        max_units_q <= max_units_i;
      end
      pending_q <= pending_d;
      seq_len_q <= seq_len_d;
      acc_q     <= acc_d;
      used_q    <= used_d;
      mode_q    <= mode_d;
    end
  end

  assign ent_valid_o = ent_valid;
  assign ent_o       = ent;

  a_swallow_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_byte_i != 8'd0 && mode_q != MODE_NORMAL) |-> !ent_valid_o)
    else $error("word queued while swallowing bytes");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_byte_i == 8'd0) |=> (used_q == 8'd0 && pending_q == 2'd0))
    else $error("terminator did not clear string state");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_valid_o && (ent_o.op == OP_UNIT || ent_o.op == OP_PAIR)) |=>
      used_q == $past(ent_o.count))
    else $error("unit count out of step with queued word");

endmodule

// ----- rtl/u8u16_fifo.sv -----
`timescale 1ns / 1ps
// short flop queue between the front and the back
// uses u8u16_pkg for the entry type

module u8u16_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8u16_pkg::entry_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output u8u16_pkg::entry_t rdata_o,
  output logic              empty_o
);
  import u8u16_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ----- rtl/u8u16_back.sv -----
`timescale 1ns / 1ps
// back part: takes queued words, splits pairs into surrogates and holds the
// current result in an output register; uses u8u16_pkg

module u8u16_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  u8u16_pkg::entry_t q_data_i,
  output logic              q_pop_o,
  output logic [15:0]       code_unit_o,
  output logic [1:0]        result_kind_o,
  output logic [7:0]        unit_count_o,
  output logic              last_o,
  output logic              empty_o,
  input  logic              pop_i
);
  import u8u16_pkg::*;

  logic              out_valid_q;
  logic [UnitW-1:0]  unit_q;
  logic [1:0]        kind_q;
  logic [CountW-1:0] count_q;
  logic              last_q;
  logic              second_q;   // low surrogate still to show
  logic [UnitW-1:0]  lo_unit_q;
  logic [CountW-1:0] lo_count_q;

  logic              load;
  logic [19:0]       supp;

  assign load    = !out_valid_q || pop_i;
  assign q_pop_o = load && !second_q && !q_empty_i;
  assign supp    = 20'(q_data_i.cp - CP_SUPP_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else if (load) begin
      if (second_q) begin
        out_valid_q <= 1'b1;
        second_q    <= 1'b0;
      end else if (!q_empty_i) begin
        out_valid_q <= 1'b1;
        second_q    <= (q_data_i.op == OP_PAIR);
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (second_q) begin
        unit_q  <= lo_unit_q;
        kind_q  <= KIND_UNIT;
        count_q <= lo_count_q;
        last_q  <= 1'b1;
      end else if (!q_empty_i) begin
        case (q_data_i.op)
          OP_UNIT: begin
            unit_q  <= q_data_i.cp[UnitW-1:0];
            kind_q  <= KIND_UNIT;
            count_q <= q_data_i.count;
            last_q  <= 1'b1;
          end
          OP_PAIR: begin
            unit_q     <= HI_SURR_BASE + {6'd0, supp[19:10]};
            kind_q     <= KIND_UNIT;
            count_q    <= q_data_i.count - 8'd1;
            last_q     <= 1'b0;
            lo_unit_q  <= LO_SURR_BASE + {6'd0, supp[9:0]};
            lo_count_q <= q_data_i.count;
          end
          OP_END_OK: begin
            unit_q  <= '0;
            kind_q  <= KIND_END_OK;
            count_q <= q_data_i.count;
            last_q  <= 1'b1;
          end
          default: begin
            unit_q  <= '0;
            kind_q  <= KIND_END_ERR;
            count_q <= q_data_i.count;
            last_q  <= 1'b1;
          end
        endcase
      end
    end
  end

  assign empty_o       = !out_valid_q;
  assign code_unit_o   = unit_q;
  assign result_kind_o = kind_q;
  assign unit_count_o  = count_q;
  assign last_o        = last_q;

  a_pair_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (out_valid_q && !last_q && kind_q == KIND_UNIT))
    else $error("low surrogate pending without high surrogate shown");

  a_high_surr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (unit_q[15:10] == 6'b110110))
    else $error("non-final word is not a high surrogate");

  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_UNIT) |-> (unit_q == '0 && last_q))
    else $error("end word carries a unit");

endmodule

// ----- rtl/utf8_to_utf16_stream_converter.sv -----
`timescale 1ns / 1ps
// utf-8 to utf-16 stream converter, top level
// uses u8u16_pkg, u8u16_front, u8u16_fifo and u8u16_back
//
// usage:
//   input queue side: drive in_byte_i and raise push; a byte is taken at an
//   edge where push is high and full is low. a zero byte ends the string.
//   result queue side: while empty is low the oldest word sits on
//   code_unit_o, result_kind_o, unit_count_o and last_o; it leaves at an
//   edge where pop is high. a pair takes two words, the high surrogate first.
//   max_units_we_i writes max_units_i as the capacity (reset value 127).
// timing:
//   a byte that gives a word enters the word queue as it is taken, then the
//   output register once that is free; the low surrogate of a pair takes the
//   ports at the edge where the high one leaves. one byte per cycle is taken
//   while the queue of QDEPTH words has room; results drain at one word per
//   cycle while pop is high, and a four-byte sequence gives at most two
//   words, so a receiver that pops every cycle never slows the input.
// reset clears the string state, the word queue and the output register and
// sets the capacity to 127.
// a receiver that holds pop low keeps its word on the ports; the queue then
// fills and full rises, after which bytes are refused until words drain.

module utf8_to_utf16_stream_converter #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        max_units_we_i,
  input  logic [7:0]  max_units_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  unit_count_o,
  output logic        last_o
);
  import u8u16_pkg::*;

  logic   accept;
  logic   ent_valid;
  entry_t ent;
  logic   q_full, q_empty, q_pop;
  entry_t q_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  u8u16_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .max_units_we_i (max_units_we_i),
    .max_units_i    (max_units_i),
    .ent_valid_o    (ent_valid),
    .ent_o          (ent)
  );

  u8u16_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ent_valid),
    .wdata_i (ent),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_data),
    .empty_o (q_empty)
  );

  u8u16_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .code_unit_o   (code_unit_o),
    .result_kind_o (result_kind_o),
    .unit_count_o  (unit_count_o),
    .last_o        (last_o),
    .empty_o       (empty),
    .pop_i         (pop)
  );

endmodule

// ----- test/utf8_to_utf16_stream_converter_tb.sv -----
`timescale 1ns / 1ps
// testbench for the utf-8 to utf-16 stream converter: table of directed bytes, then random
// strings over several capacities, every word checked against a typed value or an in-bench decoder
// depends on rtl/u8u16_pkg.sv and rtl/utf8_to_utf16_stream_converter.sv

module utf8_to_utf16_stream_converter_tb;
  import u8u16_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [UnitW-1:0]  unit;
    logic [1:0]        kind;
    logic [CountW-1:0] count;
    logic              is_last;
  } utf16_word_t;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             typed;
    utf16_word_t      w;
  } stim_row_t;

  typedef enum logic [1:0] {
    ST_DECODE,
    ST_FAULT,
    ST_HALTED
  } str_state_e;

  // typed words only where the answer is plain; other rows go through the decoder
  localparam stim_row_t DIR_ROWS [25] = '{
    '{8'h41, 1'b1, '{16'h0041, KIND_UNIT, 8'd1, 1'b1}},
    '{8'h7F, 1'b1, '{16'h007F, KIND_UNIT, 8'd2, 1'b1}},
    '{8'hC3, 1'b0, '0},
    '{8'hA9, 1'b0, '0},
    '{8'hF0, 1'b0, '0},
    '{8'h9F, 1'b0, '0},
    '{8'h98, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b1, '{16'h0000, KIND_END_OK, 8'd5, 1'b1}},
    // overlong two-byte zero
    '{8'hC0, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b1, '{16'h0000, KIND_END_ERR, 8'd0, 1'b1}},
    // bad lead byte
    '{8'hF8, 1'b0, '0},
    '{8'h00, 1'b1, '{16'h0000, KIND_END_ERR, 8'd0, 1'b1}},
    // surrogate code point
    '{8'hED, 1'b0, '0},
    '{8'hA0, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b1, '{16'h0000, KIND_END_ERR, 8'd0, 1'b1}},
    // above 0x10ffff
    '{8'hF4, 1'b0, '0},
    '{8'h90, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b1, '{16'h0000, KIND_END_ERR, 8'd0, 1'b1}},
    // string ends inside a sequence
    '{8'hE2, 1'b0, '0},
    '{8'h00, 1'b1, '{16'h0000, KIND_END_ERR, 8'd0, 1'b1}}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [7:0]  in_byte_i      = 8'h00;
  logic        max_units_we_i = 1'b0;
  logic [7:0]  max_units_i    = 8'h00;
  logic        empty;
  logic        pop            = 1'b0;
  logic [15:0] code_unit_o;
  logic [1:0]  result_kind_o;
  logic [7:0]  unit_count_o;
  logic        last_o;

  // decoder state
  logic [CountW-1:0] cap_units = 8'd127;
  logic [1:0]        cont_left = '0;
  logic [1:0]        cont_len  = '0;
  logic [CpW-1:0]    cp_acc    = '0;
  logic [CountW-1:0] units_out = '0;
  str_state_e        str_state = ST_DECODE;

  utf16_word_t      pending_words [$];
  logic [ByteW-1:0] str_bytes [$];
  int               sent_bytes  = 0;
  int               burst_left  = 0;
  int               fail_count  = 0;
  int               cycle_count = 0;
  int               rx_mode     = 0;
  int               rx_left     = 0;

  utf8_to_utf16_stream_converter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .max_units_we_i (max_units_we_i),
    .max_units_i    (max_units_i),
    .empty          (empty),
    .pop            (pop),
    .code_unit_o    (code_unit_o),
    .result_kind_o  (result_kind_o),
    .unit_count_o   (unit_count_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic emit_code_point(input logic [CpW-1:0] cp, output int n,
                                 output utf16_word_t w [2]);
    logic [CpW-1:0] floor_cp;
    logic [CpW-1:0] off;
    case (cont_len)
      2'd1:    floor_cp = 21'h000080;
      2'd2:    floor_cp = 21'h000800;
      2'd3:    floor_cp = 21'h010000;
      default: floor_cp = 21'h000000;
    endcase
    off = cp - CP_SUPP_BASE;
    if (cp < floor_cp || cp > CP_MAX || (cp > CP_SURR_LOW && cp < CP_SURR_HIGH)) begin
      str_state = ST_FAULT;
    end else if (cp <= CP_BMP_MAX) begin
      // one slot of the buffer always stays free
      if (int'(units_out) + 1 < int'(cap_units)) begin
        units_out = units_out + 8'd1;
        w[0] = '{cp[15:0], KIND_UNIT, units_out, 1'b1};
        n = 1;
      end else begin
        str_state = ST_HALTED;
      end
    end else if (int'(units_out) + 2 < int'(cap_units)) begin
      units_out = units_out + 8'd1;
      w[0] = '{HI_SURR_BASE + {6'd0, off[19:10]}, KIND_UNIT, units_out, 1'b0};
      units_out = units_out + 8'd1;
      w[1] = '{LO_SURR_BASE + {6'd0, off[9:0]}, KIND_UNIT, units_out, 1'b1};
      n = 2;
    end else begin
      str_state = ST_HALTED;
    end
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, output int n,
                             output utf16_word_t w [2]);
    n = 0;
    w[0] = '0;
    w[1] = '0;
    if (b == 8'h00) begin
      w[0].kind = (str_state == ST_FAULT || (str_state == ST_DECODE && cont_left != 0)) ?
                  KIND_END_ERR : KIND_END_OK;
      w[0].count = units_out;
      w[0].is_last = 1'b1;
      n = 1;
      cont_left = '0;
      cont_len  = '0;
      cp_acc    = '0;
      units_out = '0;
      str_state = ST_DECODE;
    end else if (str_state == ST_DECODE) begin
      if (cap_units == 8'd0) begin
        str_state = ST_HALTED;
      end else if (cont_left != 0) begin
        // prefix bits of a continuation are not looked at
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 0) emit_code_point(cp_acc, n, w);
      end else if (b < 8'h80) begin
        cont_len = 2'd0;
        emit_code_point({13'd0, b}, n, w);
      end else if (b[7:5] == 3'b110) begin
        cont_len  = 2'd1;
        cont_left = 2'd1;
        cp_acc    = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        cont_len  = 2'd2;
        cont_left = 2'd2;
        cp_acc    = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        cont_len  = 2'd3;
        cont_left = 2'd3;
        cp_acc    = {18'd0, b[2:0]};
      end else begin
        str_state = ST_FAULT;
      end
    end
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                           input utf16_word_t tw);
    int          n;
    utf16_word_t w [2];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    push      <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (full);
    sent_bytes++;
    decode_byte(b, n, w);
    if (typed) pending_words.push_back(tw);
    else for (int i = 0; i < n; i++) pending_words.push_back(w[i]);
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    // bytes that give no word add nothing to pending_words to wait on
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CountW-1:0] v);
    max_units_we_i <= 1'b1;
    max_units_i    <= v;
    @(posedge clk_i);
    max_units_we_i <= 1'b0;
    cap_units = v;
  endtask

  task automatic put_seq(input logic [CpW-1:0] cp, input int nbytes);
    logic [7:0] lead;
    logic [7:0] cb;
    case (nbytes)
      1:       lead = {1'b0, cp[6:0]};
      2:       lead = {3'b110, cp[10:6]};
      3:       lead = {4'b1110, cp[15:12]};
      default: lead = {5'b11110, cp[20:18]};
    endcase
    str_bytes.push_back(lead);
    for (int i = nbytes - 2; i >= 0; i--) begin
      cb = {2'b10, cp[6*i +: 6]};
      if ($urandom_range(0, 15) == 0) cb[7:6] = 2'($urandom);
      if (cb == 8'h00) cb = 8'h80;
      str_bytes.push_back(cb);
    end
  endtask

  task automatic put_char();
    int pick;
    int nb;
    pick = $urandom_range(0, 99);
    nb = $urandom_range(2, 4);
    if (pick < 35) put_seq(21'($urandom_range(1, 'h7F)), 1);
    else if (pick < 50) put_seq(21'($urandom_range('h80, 'h7FF)), 2);
    else if (pick < 65) put_seq(21'($urandom_range('h800, 'hFFFF)), 3);
    else if (pick < 80) put_seq(21'($urandom_range('h10000, 'h10FFFF)), 4);
    else if (pick < 85) begin
      // overlong: value below the floor of its length
      put_seq(21'($urandom_range(0, nb == 2 ? 'h7F : nb == 3 ? 'h7FF : 'hFFFF)), nb);
    end else if (pick < 88) put_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);
    else if (pick < 90) put_seq(21'($urandom_range('hD800, 'hDFFF)), 3);
    else if (pick < 93) begin
      str_bytes.push_back(pick[0] ? 8'($urandom_range('h80, 'hBF)) :
                                    8'($urandom_range('hF8, 'hFF)));
    end else if (pick < 96) begin
      // cut sequence; what follows lands in its continuation slots
      put_seq(21'($urandom_range('h80, 'h10FFFF)), nb);
      repeat ($urandom_range(1, nb - 1)) void'(str_bytes.pop_back());
    end else begin
      str_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic check_word();
    utf16_word_t exp_w;
    if (pending_words.size() == 0) begin
      $display("%0t: word with none expected: unit %h kind %0d count %0d last %b",
               $time, code_unit_o, result_kind_o, unit_count_o, last_o);
      fail_count++;
    end else begin
      exp_w = pending_words.pop_front();
      if (code_unit_o !== exp_w.unit) begin
        $display("%0t: code_unit expected %h got %h", $time, exp_w.unit, code_unit_o);
        fail_count++;
      end
      if (result_kind_o !== exp_w.kind) begin
        $display("%0t: result_kind expected %0d got %0d", $time, exp_w.kind, result_kind_o);
        fail_count++;
      end
      if (unit_count_o !== exp_w.count) begin
        $display("%0t: unit_count expected %0d got %0d", $time, exp_w.count, unit_count_o);
        fail_count++;
      end
      if (last_o !== exp_w.is_last) begin
        $display("%0t: last expected %b got %b", $time, exp_w.is_last, last_o);
        fail_count++;
      end
    end
  endtask

  // receiver: a word leaves at an edge with pop high and empty low
  always @(posedge clk_i) begin
    if (pop && !empty) check_word();
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(30, 150);
    end
    rx_left--;
    case (rx_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom);
      2:       pop <= ($urandom_range(0, 5) == 0);
      default: pop <= ((rx_left % 24) < 8);
    endcase
  end

  initial begin
    logic [CountW-1:0] caps [8];
    int                target;
    int                nchars;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIR_ROWS[i]) send_byte(DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].w);

    caps = '{8'd0, 8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 8)), 8'd3,
             8'($urandom_range(4, 40)), 8'($urandom)};
    foreach (caps[p]) begin
      drain_and_settle();
      write_capacity(caps[p]);
      target = sent_bytes + 170;
      str_bytes.delete();
      if (caps[p] == 8'd255) begin
        // long string runs the count up to the top of the buffer
        repeat (256) str_bytes.push_back(8'($urandom_range(1, 'h7F)));
        repeat (4) put_char();
        str_bytes.push_back(8'h00);
        foreach (str_bytes[k]) send_byte(str_bytes[k], 1'b0, '0);
      end
      while (sent_bytes < target) begin
        str_bytes.delete();
        nchars = $urandom_range(0, 10);
        repeat (nchars) put_char();
        str_bytes.push_back(8'h00);
        foreach (str_bytes[k]) send_byte(str_bytes[k], 1'b0, '0);
      end
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_fifo.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_stream_converter.sv
test/utf8_to_utf16_stream_converter_tb.sv
